// ===== rtl/rtcs_pkg.sv =====
// Shared types, codes and helper functions for the RTC time keeper.
package rtcs_pkg;

  // Number of chip setup bytes sent after start-up (1 to 8).
  localparam logic [3:0] SETUP_BYTES = 4'd8;

  localparam logic [5:0] SEC_MAX  = 6'd59;
  localparam logic [5:0] MIN_MAX  = 6'd59;
  localparam logic [4:0] HOUR_MAX = 5'd23;

  // Event kinds on the input channel.
  typedef enum logic [2:0] {
    KIND_TICK      = 3'd0,
    KIND_BUS_DONE  = 3'd1,
    KIND_BUTTON    = 3'd2,
    KIND_COOL_OVER = 3'd3,
    KIND_SET_TIME  = 3'd4,
    KIND_STARTUP   = 3'd5,
    KIND_READ_TIME = 3'd6
  } kind_t;

  // Commands to the bus master.
  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_WRITE     = 3'd2,
    CMD_READ_ACK  = 3'd3,
    CMD_READ_NACK = 3'd4,
    CMD_STOP      = 3'd5
  } bus_cmd_t;

  // Bus sequencer steps: time write, then setup write and time read.
  typedef enum logic [4:0] {
    STEP_IDLE       = 5'd0,
    STEP_TW_ADDR    = 5'd1,
    STEP_TW_REG     = 5'd2,
    STEP_TW_SEC     = 5'd3,
    STEP_TW_MIN     = 5'd4,
    STEP_TW_HOUR    = 5'd5,
    STEP_TW_STOP    = 5'd6,
    STEP_SU_ADDR    = 5'd7,
    STEP_SU_REG     = 5'd8,
    STEP_SU_DATA    = 5'd9,
    STEP_FETCH_WAIT = 5'd10,
    STEP_RD_REG     = 5'd11,
    STEP_RD_RESTART = 5'd12,
    STEP_RD_ADDR    = 5'd13,
    STEP_RD_FIRST   = 5'd14,
    STEP_RD_SEC     = 5'd15,
    STEP_RD_MIN     = 5'd16,
    STEP_RD_HOUR    = 5'd17
  } bus_step_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_DEVICE_ADDRESS = 2'd0,
    REG_TIME_OFFSET    = 2'd1,
    REG_SETUP_OFFSET   = 2'd2,
    REG_SETUP_PATTERN  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] rx_byte;
    logic [4:0] set_hour;
    logic [5:0] set_minute;
    logic [5:0] set_second;
    logic       set_dst;
  } in_word_t;

  typedef struct packed {
    logic [2:0] bus_cmd;
    logic [7:0] bus_byte;
    logic [4:0] shown_hour;
    logic [5:0] shown_minute;
    logic [5:0] shown_second;
    logic       dst_now;
    logic       second_passed;
    logic       cooldown_start;
  } out_word_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [7:0]  time_register_offset;
    logic [7:0]  setup_register_offset;
    logic [63:0] setup_pattern;
  } cfg_t;

  // Engine status watched at the top level.
  typedef struct packed {
    bus_step_t bus_step;
    logic      tick_masked;
    logic      fetch_pending;
  } status_t;

  // Binary value of a two-digit BCD byte (digits may exceed nine).
  function automatic logic [7:0] bcd_value(input logic [3:0] tens, input logic [3:0] ones);
    return {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0} + {4'b0000, ones};
  endfunction

  // Binary 0..59 to BCD; tens digit by multiply with 13/128.
  function automatic logic [7:0] to_bcd(input logic [5:0] v);
    logic [9:0] prod;
    logic [2:0] tens;
    logic [5:0] ones;
    prod = {4'b0000, v} * 10'd13;
    tens = prod[9:7];
    ones = v - {tens, 3'b000} - {2'b00, tens, 1'b0};
    return {1'b0, tens, ones[3:0]};
  endfunction

endpackage

// ===== rtl/rtcs_if.sv =====
// Valid/ready channel interfaces for events, results and configuration.
interface rtcs_in_if import rtcs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rtcs_out_if import rtcs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rtcs_cfg_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rtcs_cfg_regs.sv =====
// Configuration register file of the RTC time keeper.
module rtcs_cfg_regs import rtcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rtcs_cfg_if.sink   cfg,
  output cfg_t       regs
);

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register write decode.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.device_address        <= 7'd104;
      regs.time_register_offset  <= 8'd0;
      regs.setup_register_offset <= 8'd7;
      regs.setup_pattern         <= 64'd0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_DEVICE_ADDRESS: regs.device_address        <= cfg.data[6:0];
        REG_TIME_OFFSET:    regs.time_register_offset  <= cfg.data[7:0];
        REG_SETUP_OFFSET:   regs.setup_register_offset <= cfg.data[7:0];
        REG_SETUP_PATTERN:  regs.setup_pattern         <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/rtcs_engine.sv =====
// Time counters, bus sequencer and daylight-saving logic for one word per cycle while en is high.
module rtcs_engine import rtcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  in_word_t  word,
  input  cfg_t      regs,
  output out_word_t result,
  output status_t   status
);

  logic [5:0] second_count, second_count_next;
  logic [5:0] minute_count, minute_count_next;
  logic [4:0] hour_count, hour_count_next;
  bus_step_t  bus_step, bus_step_next;
  logic [3:0] setup_index, setup_index_next;
  logic [7:0] bcd_out_bytes [3];
  logic [7:0] bcd_out_next [3];
  logic [7:0] bcd_in_bytes [2];
  logic [7:0] bcd_in_next [2];
  logic       fetch_pending, fetch_pending_next;
  logic       tick_masked, tick_masked_next;
  logic       dst_flag, dst_flag_next;
  logic       dst_shifted, dst_shifted_next;
  logic       button_locked, button_locked_next;
  logic       tick_seen, tick_seen_next;

  bus_cmd_t   cmd;
  logic [7:0] tx_byte;
  logic       cool;
  logic       passed;
  logic [4:0] shown;
  logic [7:0] addr_wr, addr_rd;
  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic [5:0] hour_inc;
  logic [5:0] set_sec_sat, set_min_sat;
  logic [4:0] set_hour_sat;
  logic [7:0] rd_sec, rd_min, rd_hour;

  assign addr_wr = {regs.device_address, 1'b0};
  assign addr_rd = {regs.device_address, 1'b1};

  // Saturated set-time values.
  assign set_hour_sat = (word.set_hour > HOUR_MAX) ? HOUR_MAX : word.set_hour;
  assign set_min_sat  = (word.set_minute > MIN_MAX) ? MIN_MAX : word.set_minute;
  assign set_sec_sat  = (word.set_second > SEC_MAX) ? SEC_MAX : word.set_second;

  // Readback decode; the hour uses two bits of its tens digit.
  assign rd_sec  = bcd_value(bcd_in_bytes[0][7:4], bcd_in_bytes[0][3:0]);
  assign rd_min  = bcd_value(bcd_in_bytes[1][7:4], bcd_in_bytes[1][3:0]);
  assign rd_hour = bcd_value({2'b00, word.rx_byte[5:4]}, word.rx_byte[3:0]);

  // Next state and result for the current word.
  always_comb begin
    second_count_next  = second_count;
    minute_count_next  = minute_count;
    hour_count_next    = hour_count;
    bus_step_next      = bus_step;
    setup_index_next   = setup_index;
    bcd_out_next       = bcd_out_bytes;
    bcd_in_next        = bcd_in_bytes;
    fetch_pending_next = fetch_pending;
    tick_masked_next   = tick_masked;
    dst_flag_next      = dst_flag;
    dst_shifted_next   = dst_shifted;
    button_locked_next = button_locked;
    tick_seen_next     = tick_seen;
    cmd                = CMD_NONE;
    tx_byte            = 8'd0;
    cool               = 1'b0;
    sec_inc            = 7'd0;
    min_inc            = 7'd0;
    hour_inc           = 6'd0;

    unique case (kind_t'(word.kind))
      KIND_TICK: begin
        if (!tick_masked) begin
          sec_inc = {1'b0, second_count} + 7'd1;
          min_inc = {1'b0, minute_count};
          hour_inc = {1'b0, hour_count};
          if (sec_inc > {1'b0, SEC_MAX}) begin
            sec_inc = 7'd0;
            min_inc = min_inc + 7'd1;
          end
          if (min_inc > {1'b0, MIN_MAX}) begin
            min_inc = 7'd0;
            hour_inc = hour_inc + 6'd1;
          end
          if (hour_inc > {1'b0, HOUR_MAX}) begin
            hour_inc = 6'd0;
          end
          second_count_next = sec_inc[5:0];
          minute_count_next = min_inc[5:0];
          hour_count_next   = hour_inc[4:0];
          if (fetch_pending) begin
            fetch_pending_next = 1'b0;
            cmd = CMD_START;
          end
          tick_seen_next = 1'b1;
        end
      end
      KIND_BUS_DONE: begin
        unique case (bus_step)
          STEP_TW_ADDR: begin
            cmd = CMD_WRITE; tx_byte = addr_wr; bus_step_next = STEP_TW_REG;
          end
          STEP_TW_REG: begin
            cmd = CMD_WRITE; tx_byte = regs.time_register_offset; bus_step_next = STEP_TW_SEC;
          end
          STEP_TW_SEC: begin
            cmd = CMD_WRITE; tx_byte = bcd_out_bytes[0]; bus_step_next = STEP_TW_MIN;
          end
          STEP_TW_MIN: begin
            cmd = CMD_WRITE; tx_byte = bcd_out_bytes[1]; bus_step_next = STEP_TW_HOUR;
          end
          STEP_TW_HOUR: begin
            cmd = CMD_WRITE; tx_byte = bcd_out_bytes[2]; bus_step_next = STEP_TW_STOP;
          end
          STEP_TW_STOP: begin
            cmd = CMD_STOP; bus_step_next = STEP_IDLE; tick_masked_next = 1'b0;
          end
          STEP_SU_ADDR: begin
            cmd = CMD_WRITE; tx_byte = addr_wr; bus_step_next = STEP_SU_REG;
          end
          STEP_SU_REG: begin
            cmd = CMD_WRITE; tx_byte = regs.setup_register_offset;
            bus_step_next = STEP_SU_DATA;
          end
          STEP_SU_DATA: begin
            if (setup_index < SETUP_BYTES) begin
              cmd = CMD_WRITE;
              tx_byte = regs.setup_pattern[{setup_index[2:0], 3'b000} +: 8];
              setup_index_next = setup_index + 4'd1;
            end else begin
              setup_index_next = 4'd0;
              cmd = CMD_STOP;
              fetch_pending_next = 1'b1;
              bus_step_next = STEP_FETCH_WAIT;
            end
          end
          STEP_FETCH_WAIT: begin
            if (!fetch_pending) begin
              cmd = CMD_WRITE; tx_byte = addr_wr; bus_step_next = STEP_RD_REG;
            end
          end
          STEP_RD_REG: begin
            cmd = CMD_WRITE; tx_byte = regs.time_register_offset;
            bus_step_next = STEP_RD_RESTART;
          end
          STEP_RD_RESTART: begin
            cmd = CMD_START; bus_step_next = STEP_RD_ADDR;
          end
          STEP_RD_ADDR: begin
            cmd = CMD_WRITE; tx_byte = addr_rd; bus_step_next = STEP_RD_FIRST;
          end
          STEP_RD_FIRST: begin
            cmd = CMD_READ_ACK; bus_step_next = STEP_RD_SEC;
          end
          STEP_RD_SEC: begin
            bcd_in_next[0] = word.rx_byte; cmd = CMD_READ_ACK; bus_step_next = STEP_RD_MIN;
          end
          STEP_RD_MIN: begin
            bcd_in_next[1] = word.rx_byte; cmd = CMD_READ_NACK; bus_step_next = STEP_RD_HOUR;
          end
          STEP_RD_HOUR: begin
            second_count_next = (rd_sec > {2'b00, SEC_MAX}) ? SEC_MAX : rd_sec[5:0];
            minute_count_next = (rd_min > {2'b00, MIN_MAX}) ? MIN_MAX : rd_min[5:0];
            hour_count_next   = (rd_hour > {3'b000, HOUR_MAX}) ? HOUR_MAX : rd_hour[4:0];
            cmd = CMD_STOP;
            bus_step_next = STEP_IDLE;
          end
          default: ;
        endcase
      end
      KIND_BUTTON: begin
        if (!button_locked) begin
          button_locked_next = 1'b1;
          dst_shifted_next = !dst_shifted;
          cool = 1'b1;
        end
      end
      KIND_COOL_OVER: begin
        button_locked_next = 1'b0;
      end
      KIND_SET_TIME: begin
        hour_count_next    = set_hour_sat;
        minute_count_next  = set_min_sat;
        second_count_next  = set_sec_sat;
        bcd_out_next[0]    = to_bcd(set_sec_sat);
        bcd_out_next[1]    = to_bcd(set_min_sat);
        bcd_out_next[2]    = to_bcd({1'b0, set_hour_sat});
        tick_masked_next   = 1'b1;
        fetch_pending_next = 1'b0;
        bus_step_next      = STEP_TW_ADDR;
        cmd                = CMD_START;
        dst_flag_next      = word.set_dst;
        dst_shifted_next   = 1'b0;
      end
      KIND_STARTUP: begin
        bus_step_next      = STEP_SU_ADDR;
        setup_index_next   = 4'd0;
        fetch_pending_next = 1'b0;
        tick_masked_next   = 1'b0;
        cmd                = CMD_START;
      end
      default: ;
    endcase

    // A read-time event reports the flag and then clears it.
    passed = tick_seen_next;
    if (word.kind == KIND_READ_TIME) begin
      tick_seen_next = 1'b0;
    end

    // Daylight-saving shift of the shown hour.
    shown = hour_count_next;
    if (dst_shifted_next) begin
      if (dst_flag_next) begin
        shown = (shown == 5'd0) ? HOUR_MAX : shown - 5'd1;
      end else begin
        shown = (shown >= HOUR_MAX) ? 5'd0 : shown + 5'd1;
      end
    end
  end

  assign result.bus_cmd        = cmd;
  assign result.bus_byte       = tx_byte;
  assign result.shown_hour     = shown;
  assign result.shown_minute   = minute_count_next;
  assign result.shown_second   = second_count_next;
  assign result.dst_now        = dst_flag_next;
  assign result.second_passed  = passed;
  assign result.cooldown_start = cool;

  assign status.bus_step      = bus_step;
  assign status.tick_masked   = tick_masked;
  assign status.fetch_pending = fetch_pending;

  // State registers, updated once per processed word.
  always_ff @(posedge clk) begin
    if (rst) begin
      second_count     <= 6'd0;
      minute_count     <= 6'd0;
      hour_count       <= 5'd0;
      bus_step         <= STEP_IDLE;
      setup_index      <= 4'd0;
      bcd_out_bytes[0] <= 8'd0;
      bcd_out_bytes[1] <= 8'd0;
      bcd_out_bytes[2] <= 8'd0;
      bcd_in_bytes[0]  <= 8'd0;
      bcd_in_bytes[1]  <= 8'd0;
      fetch_pending    <= 1'b0;
      tick_masked      <= 1'b0;
      dst_flag         <= 1'b0;
      dst_shifted      <= 1'b0;
      button_locked    <= 1'b0;
      tick_seen        <= 1'b0;
    end else if (en) begin
      second_count  <= second_count_next;
      minute_count  <= minute_count_next;
      hour_count    <= hour_count_next;
      bus_step      <= bus_step_next;
      setup_index   <= setup_index_next;
      bcd_out_bytes <= bcd_out_next;
      bcd_in_bytes  <= bcd_in_next;
      fetch_pending <= fetch_pending_next;
      tick_masked   <= tick_masked_next;
      dst_flag      <= dst_flag_next;
      dst_shifted   <= dst_shifted_next;
      button_locked <= button_locked_next;
      tick_seen     <= tick_seen_next;
    end
  end

endmodule

// ===== rtl/rtc_time_sync_clock_core.sv =====
// Top level of the RTC time keeper: input register, engine, result register.
//
//   channel  direction  payload                                   handshake
//   evt      in         kind, rx_byte, set_hour/minute/second/dst valid/ready
//   res      out        bus_cmd, bus_byte, shown time, flags      valid/ready
//   cfg      in         index (2 bits), data (64 bits)            valid/ready
//
// One event word is taken per cycle while ready is high. The accepting edge
// loads the input register; the word moves on into the result register when
// that register is empty or being read, and one result comes per event.
// The engine state updates when a word moves from the input register to the
// result register, so the next word sees it. A stalled result register holds
// its word; the input register still fills once, then ready drops.
// Reset is synchronous and sets the valid flags and engine state to zero and the registers to defaults.
module rtc_time_sync_clock_core import rtcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rtcs_in_if.sink    evt,
  rtcs_out_if.source res,
  rtcs_cfg_if.sink   cfg
);

  logic      in_valid_q;
  in_word_t  in_word_q;
  logic      out_valid_q;
  out_word_t out_word_q;
  logic      advance;
  logic      fire;
  cfg_t      regs;
  out_word_t result;
  status_t   status;

  assign advance   = !out_valid_q || res.ready;
  assign fire      = in_valid_q && advance;
  assign evt.ready = !in_valid_q || advance;
  assign res.valid = out_valid_q;
  assign res.data  = out_word_q;

  rtcs_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  rtcs_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .en     (fire),
    .word   (in_word_q),
    .regs   (regs),
    .result (result),
    .status (status)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (evt.ready) begin
      in_valid_q <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      in_word_q <= evt.data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word_q <= result;
    end
  end

  // A held word moves on whenever the result register is empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && !out_valid_q |=> out_valid_q)
    else $error("input word did not reach the result register");

  // Ticks are masked exactly while a time write is on the bus.
  a_mask: assert property (@(posedge clk) disable iff (rst)
    status.tick_masked == (status.bus_step >= STEP_TW_ADDR &&
                           status.bus_step <= STEP_TW_STOP))
    else $error("tick mask out of step with time write");

  // A pending fetch only exists while waiting for the fetch tick.
  a_fetch: assert property (@(posedge clk) disable iff (rst)
    status.fetch_pending |-> status.bus_step == STEP_FETCH_WAIT)
    else $error("fetch pending outside the fetch wait step");

endmodule
